@@ src/fbfl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fbfl_pkg;

	localparam int ADDR_W    = 32;
	localparam int SIZE_BITS = 13;
	localparam int COUNT_W   = 8;
	localparam int OFF_BITS  = 20;
	localparam int MAX_BYTES = 4096;

	typedef enum logic [1:0] {
		OP_ACQUIRE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_QUERY   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NONE     = 2'd1,
		ST_ALL_FREE = 2'd2,
		ST_BAD_ADDR = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OWN_BELOW  = 2'd0,
		OWN_INSIDE = 2'd1,
		OWN_ABOVE  = 2'd2
	} own_t;

	typedef enum logic [1:0] {
		REG_BASE  = 2'd0,
		REG_BYTES = 2'd1,
		REG_COUNT = 2'd2
	} reg_idx_t;

	// block count clamped to 1..max_count
	function automatic logic [COUNT_W-1:0] sat_count(
		input logic [COUNT_W-1:0] c,
		input logic [COUNT_W-1:0] max_count
	);
		logic [COUNT_W-1:0] r;
		r = c;
		if (c == '0) begin
			r = COUNT_W'(1);
		end else if (c > max_count) begin
			r = max_count;
		end
		return r;
	endfunction

	// block size clamped to 1..4096
	function automatic logic [SIZE_BITS-1:0] sat_bytes(input logic [SIZE_BITS-1:0] b);
		logic [SIZE_BITS-1:0] r;
		r = b;
		if (b == '0) begin
			r = SIZE_BITS'(1);
		end else if (b > SIZE_BITS'(MAX_BYTES)) begin
			r = SIZE_BITS'(MAX_BYTES);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ src/fbfl_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module fbfl_divider import fbfl_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [OFF_BITS-1:0]  dividend,
	input  wire logic [SIZE_BITS-1:0] divisor,
	output logic                      done,
	output logic [OFF_BITS-1:0]       quotient,
	output logic [SIZE_BITS-1:0]      remainder
);

	localparam int CW = $clog2(OFF_BITS + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic [OFF_BITS-1:0]  quo_q;
	logic [SIZE_BITS-1:0] rem_q;
	logic [SIZE_BITS-1:0] dsr_q;

	logic [SIZE_BITS:0] shifted;
	logic [SIZE_BITS:0] diff;
	logic               fits;

	assign shifted = {rem_q, quo_q[OFF_BITS-1]};
	assign fits    = shifted >= {1'b0, dsr_q};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(OFF_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[SIZE_BITS-1:0] : shifted[SIZE_BITS-1:0];
			quo_q <= {quo_q[OFF_BITS-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

@@ src/fixed_block_free_list_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// fixed-block free-list allocator for one chunk of equal blocks
// input channel: in_valid / in_stall carry one word (operation, address);
//   acquire pops the head of the free list, release pushes the block that an
//   address names, query reports where an address lies against the chunk
// output channel: out_valid / out_stall carry one result word per input word
// config port: cfg_write with cfg_index 0 base, 1 block size, 2 block count;
//   a write of the block count reformats the free list at once
// sequence: acquire and query pass S_MUL, S_CHECK and S_DONE; a release that
//   passes its checks also waits in S_DIV for the restoring divider, which turns the
//   offset into a block index one quotient bit per cycle (20 bits)
// one word at a time; in_stall is high from accept until the
//   result has moved into the output register; only then can a new word follow
// a finished result waits in the output register while out_stall is high,
//   and the next input word is accepted meanwhile; that word's result waits
//   in its last state until the output register frees up
// reset: base 0, block size 16, block count 255 clamped to MAX_BLOCKS, an
//   empty output register and a freshly formatted list; link table entries
//   carry valid bits, so no clearing pass is needed
module fixed_block_free_list_allocator import fbfl_pkg::*; #(
	parameter int MAX_BLOCKS   = 255,
	parameter int ADDRESS_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            operation,
	input  wire logic [ADDR_W-1:0]     address,
	// output channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [ADDR_W-1:0]          block_address,
	output logic [COUNT_W-1:0]         block_index,
	output logic [1:0]                 status,
	output logic [1:0]                 ownership,
	output logic [COUNT_W-1:0]         free_count,
	output logic                       all_free,
	// config port
	input  wire logic                  cfg_write,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [ADDR_W-1:0]     cfg_data
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int AW = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << AW) - 64'd1);
	localparam logic [COUNT_W-1:0] MAX_CNT  = COUNT_W'(MAX_BLOCKS);
	localparam int MW = COUNT_W + SIZE_BITS;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MUL   = 5'b00010,
		S_CHECK = 5'b00100,
		S_DIV   = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [ADDR_W-1:0]    base_q;
	logic [SIZE_BITS-1:0] bytes_q;
	logic [COUNT_W-1:0]   count_q;
	logic [SIZE_BITS-1:0] eff_bytes;
	logic [COUNT_W-1:0]   eff_cnt;
	logic [ADDR_W-1:0]    base_m;

	// free list
	logic [COUNT_W-1:0]    head_q;
	logic [COUNT_W-1:0]    free_q;
	logic [COUNT_W-1:0]    mem_q [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] vld_q;
	logic [COUNT_W-1:0]    rd_data_q;
	logic                  rd_vld_q;
	logic                  head_in_table;

	// current word
	logic [1:0]        op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [MW-1:0]     mul_q;
	logic [COUNT_W-1:0] mul_a;

	// result held until the output register frees up
	logic [ADDR_W-1:0]  res_addr_q;
	logic [COUNT_W-1:0] res_index_q;
	status_t            res_status_q;
	own_t               res_own_q;

	// output register
	logic               out_valid_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [COUNT_W-1:0] out_index_q;
	logic [1:0]         out_status_q;
	logic [1:0]         out_own_q;
	logic [COUNT_W-1:0] out_free_q;
	logic               out_all_q;

	// divider
	logic                 div_start;
	logic                 div_done;
	logic [OFF_BITS-1:0]  div_quo;
	logic [SIZE_BITS-1:0] div_rem;
	logic [OFF_BITS-1:0]  offset;

	logic in_fire;
	logic out_free_slot;
	logic is_acq, is_rel;
	logic [ADDR_W:0] chunk_end;
	own_t            own_now;
	logic            commit;
	logic            acq_pop;
	logic [COUNT_W-1:0] next_head;

	assign eff_bytes = sat_bytes(bytes_q);
	assign eff_cnt   = sat_count(count_q, MAX_CNT);
	assign base_m    = base_q & ADDR_MASK;

	assign in_stall      = (state_q != S_IDLE);
	assign in_fire       = in_valid && !in_stall;
	assign out_free_slot = !out_valid_q || !out_stall;

	assign is_acq = (op_q == OP_ACQUIRE);
	assign is_rel = (op_q == OP_RELEASE);

	// one shared multiplier: block offset on acquire, chunk size otherwise
	assign mul_a = is_acq ? head_q : eff_cnt;

	assign head_in_table = head_q < MAX_CNT;
	assign chunk_end     = {1'b0, base_m} + (ADDR_W + 1)'(mul_q);
	assign offset        = OFF_BITS'(addr_q - base_m);

	always_comb begin
		if (addr_q < base_m) begin
			own_now = OWN_BELOW;
		end else if ({1'b0, addr_q} >= chunk_end) begin
			own_now = OWN_ABOVE;
		end else begin
			own_now = OWN_INSIDE;
		end
	end

	// unwritten link entries read as index plus one
	always_comb begin
		if (!head_in_table) begin
			next_head = '0;
		end else if (rd_vld_q) begin
			next_head = rd_data_q;
		end else begin
			next_head = head_q + COUNT_W'(1);
		end
	end

	assign acq_pop   = (state_q == S_CHECK) && is_acq && (free_q != '0);
	assign div_start = (state_q == S_CHECK) && is_rel && (free_q < eff_cnt)
		&& (own_now == OWN_INSIDE);
	assign commit    = (state_q == S_DIV) && div_done && (div_rem == '0)
		&& (div_quo < OFF_BITS'(MAX_BLOCKS));

	fbfl_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (offset),
		.divisor   (eff_bytes),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) state_d = S_MUL;
			end
			S_MUL: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = div_start ? S_DIV : S_DONE;
			end
			S_DIV: begin
				if (div_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free_slot) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers and list control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			bytes_q <= SIZE_BITS'(16);
			count_q <= COUNT_W'(255);
			head_q  <= '0;
			free_q  <= sat_count(COUNT_W'(255), MAX_CNT);
			vld_q   <= '0;
		end else begin
			if (acq_pop) begin
				head_q <= next_head;
				free_q <= free_q - COUNT_W'(1);
			end
			if (commit) begin
				head_q <= div_quo[COUNT_W-1:0];
				free_q <= free_q + COUNT_W'(1);
				vld_q[div_quo[IW-1:0]] <= 1'b1;
			end
			if (cfg_write) begin
				unique case (cfg_index)
					REG_BASE:  base_q  <= cfg_data;
					REG_BYTES: bytes_q <= cfg_data[SIZE_BITS-1:0];
					REG_COUNT: begin
						count_q <= cfg_data[COUNT_W-1:0];
						head_q  <= '0;
						free_q  <= sat_count(cfg_data[COUNT_W-1:0], MAX_CNT);
						vld_q   <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// link table: one write, one registered read
	always_ff @(posedge clk) begin
		if (commit) begin
			mem_q[div_quo[IW-1:0]] <= head_q;
		end
		if (state_q == S_MUL) begin
			rd_data_q <= mem_q[head_q[IW-1:0]];
			rd_vld_q  <= vld_q[head_q[IW-1:0]];
		end
	end

	// word registers and shared multiplier
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= operation;
			addr_q <= address & ADDR_MASK;
		end
		if (state_q == S_MUL) begin
			mul_q <= MW'(mul_a) * MW'(eff_bytes);
		end
	end

	// result assembly
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			res_addr_q   <= '0;
			res_index_q  <= '0;
			res_status_q <= ST_OK;
			res_own_q    <= OWN_BELOW;
			if (is_acq) begin
				if (free_q == '0) begin
					res_status_q <= ST_NONE;
				end else begin
					res_addr_q  <= (base_m + ADDR_W'(mul_q)) & ADDR_MASK;
					res_index_q <= head_q;
				end
			end else begin
				res_own_q <= own_now;
				if (is_rel) begin
					if (free_q >= eff_cnt) begin
						res_status_q <= ST_ALL_FREE;
					end else if (own_now != OWN_INSIDE) begin
						res_status_q <= ST_BAD_ADDR;
					end
				end
			end
		end
		if ((state_q == S_DIV) && div_done) begin
			if (commit) begin
				res_index_q <= div_quo[COUNT_W-1:0];
			end else begin
				res_status_q <= ST_BAD_ADDR;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free_slot) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free_slot) begin
			out_addr_q   <= res_addr_q;
			out_index_q  <= res_index_q;
			out_status_q <= res_status_q;
			out_own_q    <= res_own_q;
			out_free_q   <= free_q;
			out_all_q    <= free_q >= eff_cnt;
		end
	end

	assign out_valid     = out_valid_q;
	assign block_address = out_addr_q;
	assign block_index   = out_index_q;
	assign status        = out_status_q;
	assign ownership     = out_own_q;
	assign free_count    = out_free_q;
	assign all_free      = out_all_q;

endmodule

`default_nettype wire

@@ verif/fixed_block_free_list_allocator_tb.sv @@
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_tb;
	import fbfl_pkg::*;

	localparam int CHUNK_SLOTS = 255;
	localparam int SPAN_W      = ADDR_W + 2;
	localparam int CYCLE_LIMIT = 400000;

	// operation code three behaves as a query
	localparam logic [1:0] OP_QUERY_ALIAS = 2'd3;
	// register index with no register behind it
	localparam logic [1:0] REG_SPARE      = 2'd3;

	// one result word as the block should present it
	typedef struct packed {
		logic [ADDR_W-1:0]  blk_addr;
		logic [COUNT_W-1:0] blk_idx;
		status_t            st;
		own_t               own;
		logic [COUNT_W-1:0] nfree;
		logic               chunk_idle;
	} alloc_outcome_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         operation;
	logic [ADDR_W-1:0]  address;
	logic               out_valid;
	logic               out_stall;
	logic [ADDR_W-1:0]  block_address;
	logic [COUNT_W-1:0] block_index;
	logic [1:0]         status;
	logic [1:0]         ownership;
	logic [COUNT_W-1:0] free_count;
	logic               all_free;
	logic               cfg_write;
	logic [1:0]         cfg_index;
	logic [ADDR_W-1:0]  cfg_data;

	// shadow copy of the chunk: registers, link table, head and free count
	logic [ADDR_W-1:0]    chunk_base;
	logic [SIZE_BITS-1:0] size_reg;
	logic [COUNT_W-1:0]   count_reg;
	logic [COUNT_W-1:0]   link_table [CHUNK_SLOTS];
	logic [COUNT_W-1:0]   list_head;
	logic [COUNT_W-1:0]   free_left;

	// results owed by the block, oldest first
	alloc_outcome_t alloc_outcomes [$];
	// blocks handed out and not yet given back, used to aim releases
	logic [COUNT_W-1:0] held_blocks [$];

	alloc_outcome_t oldest;
	int             mismatches;
	int             cycles;
	bit             no_idle;

	fixed_block_free_list_allocator #(
		.MAX_BLOCKS   (CHUNK_SLOTS),
		.ADDRESS_BITS (ADDR_W)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.address       (address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.block_address (block_address),
		.block_index   (block_index),
		.status        (status),
		.ownership     (ownership),
		.free_count    (free_count),
		.all_free      (all_free),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// block count as the block uses it: zero reads as one, capped at CHUNK_SLOTS
	function automatic logic [COUNT_W-1:0] live_count();
		if (count_reg == '0) begin
			return COUNT_W'(1);
		end
		if (int'(count_reg) > CHUNK_SLOTS) begin
			return COUNT_W'(CHUNK_SLOTS);
		end
		return count_reg;
	endfunction

	// block size as the block uses it: zero reads as one, capped at 4096
	function automatic logic [SIZE_BITS-1:0] live_size();
		if (size_reg == '0) begin
			return SIZE_BITS'(1);
		end
		if (size_reg > SIZE_BITS'(MAX_BYTES)) begin
			return SIZE_BITS'(MAX_BYTES);
		end
		return size_reg;
	endfunction

	// fresh list: every entry links to the next, head at block zero
	function automatic void format_free_list();
		for (int i = 0; i < CHUNK_SLOTS; i++) begin
			link_table[i] = COUNT_W'(i + 1);
		end
		list_head = '0;
		free_left = live_count();
		held_blocks.delete();
	endfunction

	// apply one word to the shadow chunk and work out its result
	function automatic void step_free_list(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
			output alloc_outcome_t r);
		logic [COUNT_W-1:0]   cnt;
		logic [SIZE_BITS-1:0] sz;
		logic [SPAN_W-1:0]    chunk_end;
		logic [ADDR_W-1:0]    off;
		logic [ADDR_W-1:0]    idx;
		cnt = live_count();
		sz = live_size();
		r = '0;
		r.st = ST_OK;
		r.own = OWN_BELOW;
		if (op == OP_ACQUIRE) begin
			if (free_left == '0) begin
				r.st = ST_NONE;
			end else begin
				// block address wraps at the top of the address space
				r.blk_addr = chunk_base + ADDR_W'(list_head) * ADDR_W'(sz);
				r.blk_idx = list_head;
				list_head = (int'(list_head) < CHUNK_SLOTS) ? link_table[list_head] : '0;
				free_left = free_left - COUNT_W'(1);
			end
		end else begin
			// range test without wrap: the chunk end may lie past 2^32
			chunk_end = SPAN_W'(chunk_base) + SPAN_W'(sz) * SPAN_W'(cnt);
			if (SPAN_W'(addr) < SPAN_W'(chunk_base)) begin
				r.own = OWN_BELOW;
			end else if (SPAN_W'(addr) >= chunk_end) begin
				r.own = OWN_ABOVE;
			end else begin
				r.own = OWN_INSIDE;
			end
			if (op == OP_RELEASE) begin
				// all-free check wins over the address check
				if (free_left >= cnt) begin
					r.st = ST_ALL_FREE;
				end else if (r.own != OWN_INSIDE) begin
					r.st = ST_BAD_ADDR;
				end else begin
					off = addr - chunk_base;
					idx = off / ADDR_W'(sz);
					if (off % ADDR_W'(sz) != '0 || idx >= CHUNK_SLOTS) begin
						r.st = ST_BAD_ADDR;
					end else begin
						link_table[idx[COUNT_W-1:0]] = list_head;
						list_head = idx[COUNT_W-1:0];
						free_left = free_left + COUNT_W'(1);
						r.blk_idx = idx[COUNT_W-1:0];
					end
				end
			end
		end
		r.nfree = free_left;
		r.chunk_idle = (free_left >= cnt);
	endfunction

	task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
			input logic [ADDR_W-1:0] want);
		$display("%0t: %s got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// offer one word, hold it until taken, then log what it should return
	task automatic send_word(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
		int             gap;
		alloc_outcome_t r;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		address <= addr;
		do @(posedge clk); while (in_stall !== 1'b0);
		step_free_list(op, addr, r);
		alloc_outcomes.push_back(r);
		if (op == OP_ACQUIRE && r.st == ST_OK) begin
			held_blocks.push_back(r.blk_idx);
		end
		if (op == OP_RELEASE && r.st == ST_OK) begin
			for (int i = 0; i < held_blocks.size(); i++) begin
				if (held_blocks[i] == r.blk_idx) begin
					held_blocks.delete(i);
					break;
				end
			end
		end
	endtask

	// drop valid and let every owed result come out
	task automatic wait_block_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (alloc_outcomes.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_BASE: chunk_base = data;
			REG_BYTES: size_reg = data[SIZE_BITS-1:0];
			REG_COUNT: begin
				// only a count write reformats the list
				count_reg = data[COUNT_W-1:0];
				format_free_list();
			end
			default: ;
		endcase
	endtask

	// one random word: an acquire by acq_pct, else a release (often aimed at blocks that are out) or a query
	task automatic send_random_word(input int acq_pct);
		int                   pick;
		logic [COUNT_W-1:0]   cnt;
		logic [SIZE_BITS-1:0] sz;
		logic [ADDR_W-1:0]    span;
		logic [ADDR_W-1:0]    spot;
		cnt = live_count();
		sz = live_size();
		span = ADDR_W'(sz) * ADDR_W'(cnt);
		spot = chunk_base + ADDR_W'(sz) * ADDR_W'($urandom_range(0, cnt - 1));
		pick = $urandom_range(0, 99);
		if (pick < acq_pct) begin
			send_word(OP_ACQUIRE, $urandom());
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				if (held_blocks.size() != 0) begin
					spot = chunk_base + ADDR_W'(sz) *
						ADDR_W'(held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
				end
				send_word(OP_RELEASE, spot);
			end else if (pick < 68) begin
				// any block boundary, so double frees happen too
				send_word(OP_RELEASE, spot);
			end else if (pick < 76) begin
				// off the block boundary, unless blocks are one byte
				send_word(OP_RELEASE, spot + ADDR_W'($urandom_range(1, (sz > 1) ? sz - 1 : 1)));
			end else if (pick < 84) begin
				send_word(OP_RELEASE, $urandom());
			end else if (pick < 94) begin
				// around both edges of the chunk
				send_word(OP_QUERY, chunk_base - ADDR_W'(3) + ADDR_W'($urandom_range(0, span + 6)));
			end else begin
				send_word(($urandom_range(0, 1) == 0) ? OP_QUERY : OP_QUERY_ALIAS, $urandom());
			end
		end
	endtask

	// random traffic with bursts of back-to-back words now and then
	task automatic run_traffic(input int words, input int acq_pct);
		for (int n = 0; n < words; n++) begin
			if (n % 40 == 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
			end
			send_random_word(acq_pct);
		end
		no_idle = 1'b0;
		wait_block_idle();
	endtask

	// reset settings: base 0, 16-byte blocks, 255 blocks
	task automatic test_fresh_chunk();
		send_word(OP_QUERY, 32'h0000_0000);
		send_word(OP_QUERY, 32'hFFFF_FFFF);
		// first byte past the chunk, through code three
		send_word(OP_QUERY_ALIAS, 32'd4080);
		// nothing is out yet
		send_word(OP_RELEASE, 32'h0000_0000);
		send_word(OP_ACQUIRE, 32'hFFFF_FFFF);
		send_word(OP_ACQUIRE, 32'h0000_0000);
		wait_block_idle();
	endtask

	task automatic test_bad_releases();
		send_word(OP_RELEASE, 32'd8);
		send_word(OP_RELEASE, 32'd4080);
		send_word(OP_RELEASE, 32'hFFFF_FFFF);
		send_word(OP_RELEASE, 32'd16);
		send_word(OP_RELEASE, 32'd0);
		wait_block_idle();
	endtask

	// zero count and zero size both read as one: a one-byte, one-block chunk
	task automatic test_single_block();
		write_reg(REG_BASE, 32'h8000_0000);
		write_reg(REG_BYTES, 32'hFFFF_E000);
		write_reg(REG_COUNT, 32'hFFFF_FF00);
		send_word(OP_ACQUIRE, 32'h0000_0000);
		send_word(OP_ACQUIRE, 32'h8000_0000);
		send_word(OP_RELEASE, 32'h7FFF_FFFF);
		send_word(OP_RELEASE, 32'h8000_0001);
		send_word(OP_QUERY, 32'h7FFF_FFFF);
		send_word(OP_RELEASE, 32'h8000_0000);
		send_word(OP_RELEASE, 32'h8000_0000);
		wait_block_idle();
	endtask

	// chunk runs past the top of the address space, oversized block size
	task automatic test_config_extremes();
		write_reg(REG_BASE, 32'hFFFF_FF00);
		write_reg(REG_BYTES, 32'h0000_1FFF);
		write_reg(REG_COUNT, 32'h5A5A_5AFF);
		send_word(OP_ACQUIRE, 32'h0000_0000);
		// second block address wraps to the bottom
		send_word(OP_ACQUIRE, 32'h0000_0000);
		send_word(OP_QUERY, 32'hFFFF_FFFF);
		send_word(OP_QUERY, 32'h0000_0000);
		send_word(OP_RELEASE, 32'h0000_0F00);
		send_word(OP_RELEASE, 32'hFFFF_FF00);
		wait_block_idle();
		// write to the spare index must change nothing
		write_reg(REG_SPARE, $urandom());
		send_word(OP_QUERY, 32'hFFFF_FF00);
		wait_block_idle();
	endtask

	task automatic test_random_traffic();
		logic [SIZE_BITS-1:0] sz;
		logic [COUNT_W-1:0]   cnt;
		// full chunk: run it dry, then give some of it back
		write_reg(REG_BASE, $urandom());
		write_reg(REG_BYTES, 32'd16);
		write_reg(REG_COUNT, CHUNK_SLOTS);
		run_traffic(280, 95);
		run_traffic(100, 15);
		// tiny chunk of one-byte blocks: empty and full all the time
		write_reg(REG_COUNT, 32'd3);
		write_reg(REG_BYTES, 32'd1);
		write_reg(REG_BASE, $urandom());
		run_traffic(120, 50);
		// largest block size near the top of the address space
		write_reg(REG_BASE, 32'hFFFF_F800);
		write_reg(REG_BYTES, MAX_BYTES);
		write_reg(REG_COUNT, 32'd200);
		run_traffic(100, 55);
		// random settings; sometimes the count is left alone, so no reformat
		repeat (6) begin
			sz = SIZE_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
				: $urandom_range(1, 64));
			cnt = COUNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
				: $urandom_range(1, 12));
			write_reg(REG_BASE, $urandom());
			write_reg(REG_BYTES, {$urandom()} & 32'hFFFF_E000 | ADDR_W'(sz));
			if ($urandom_range(0, 3) != 0) begin
				write_reg(REG_COUNT, {$urandom()} & 32'hFFFF_FF00 | ADDR_W'(cnt));
			end
			run_traffic(40, $urandom_range(30, 70));
		end
	endtask

	// receiver: random stall before each result word, none during bursts
	initial begin
		int hold;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			hold = no_idle ? 0 : $urandom_range(0, 19);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_stall == 1'b0));
		end
	end

	// every result word taken is checked against the oldest owed one
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (alloc_outcomes.size() == 0) begin
				report_mismatch("result word with nothing owed", block_address, '0);
			end else begin
				oldest = alloc_outcomes.pop_front();
				if (block_address !== oldest.blk_addr) begin
					report_mismatch("block_address", block_address, oldest.blk_addr);
				end
				if (block_index !== oldest.blk_idx) begin
					report_mismatch("block_index", ADDR_W'(block_index),
						ADDR_W'(oldest.blk_idx));
				end
				if (status !== oldest.st) begin
					report_mismatch("status", ADDR_W'(status), ADDR_W'(oldest.st));
				end
				if (ownership !== oldest.own) begin
					report_mismatch("ownership", ADDR_W'(ownership), ADDR_W'(oldest.own));
				end
				if (free_count !== oldest.nfree) begin
					report_mismatch("free_count", ADDR_W'(free_count), ADDR_W'(oldest.nfree));
				end
				if (all_free !== oldest.chunk_idle) begin
					report_mismatch("all_free", ADDR_W'(all_free), ADDR_W'(oldest.chunk_idle));
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ACQUIRE;
		address = '0;
		cfg_write = 1'b0;
		cfg_index = REG_BASE;
		cfg_data = '0;
		mismatches = 0;
		cycles = 0;
		no_idle = 1'b0;
		// shadow chunk starts from the reset settings
		chunk_base = '0;
		size_reg = SIZE_BITS'(16);
		count_reg = COUNT_W'(CHUNK_SLOTS);
		format_free_list();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_fresh_chunk();
		test_bad_releases();
		test_single_block();
		test_config_extremes();
		test_random_traffic();

		// let any stray word show up before the verdict
		repeat (40) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/fbfl_pkg.sv
src/fbfl_divider.sv
src/fixed_block_free_list_allocator.sv
verif/fixed_block_free_list_allocator_tb.sv
